// ----- rtl/pcorr_pkg.sv -----
// ----------------------------------------------------------------------------
// pcorr_pkg
// Shared types, codes and constants of the Pearson correlation block.
// ----------------------------------------------------------------------------
package pcorr_pkg;

    localparam int DEF_MAX_SAMPLES = 65536;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int WORD_W    = 64;
    localparam int HALF_W    = 32;
    localparam int DWORD_W   = 128;
    localparam int FRAC_BITS = 14;
    localparam int Q_BITS    = FRAC_BITS + 1;
    localparam int SRCH_W    = 160;
    localparam int BIT_W     = $clog2(Q_BITS);
    localparam int R_W       = 16;
    localparam int STATUS_W  = 2;

    localparam logic [BIT_W-1:0] SRCH_TOP = BIT_W'(Q_BITS - 1);

    localparam int MSTEP_W = 3;
    localparam logic [MSTEP_W-1:0] MUL_LAST_STEP = 3'd4;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_DEGEN = 2'd1;
    localparam status_t ST_OVF   = 2'd2;

    typedef logic [2:0] mul_op_t;
    localparam mul_op_t OP_N_XY    = 3'd0;
    localparam mul_op_t OP_X_Y     = 3'd1;
    localparam mul_op_t OP_N_XX    = 3'd2;
    localparam mul_op_t OP_X_X     = 3'd3;
    localparam mul_op_t OP_N_YY    = 3'd4;
    localparam mul_op_t OP_Y_Y     = 3'd5;
    localparam mul_op_t OP_SXX_SYY = 3'd6;
    localparam mul_op_t OP_MAG_MAG = 3'd7;

    typedef struct packed {
        logic    accum;
        logic    clear;
        logic    mul_start;
        mul_op_t mul_op;
        logic    srch_trial;
        logic    srch_decide;
        logic    srch_first;
        logic    out_load;
    } pcorr_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic degenerate;
        logic overflow;
        logic out_free;
    } pcorr_sts_t;

endpackage

// ----- rtl/pcorr_mul.sv -----
// ----------------------------------------------------------------------------
// pcorr_mul
// 64x64 unsigned multiplier built from one 32x32 multiplier over four steps.
// ----------------------------------------------------------------------------
module pcorr_mul
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pcorr_pkg::WORD_W-1:0]  a,
    input  logic [pcorr_pkg::WORD_W-1:0]  b,
    output logic                          done,
    output logic [pcorr_pkg::DWORD_W-1:0] prod
);

    localparam int HW = pcorr_pkg::HALF_W;

    logic [pcorr_pkg::WORD_W-1:0]  a_reg;
    logic [pcorr_pkg::WORD_W-1:0]  b_reg;
    logic [pcorr_pkg::DWORD_W-1:0] acc_reg;
    logic [2*HW-1:0]               pp_reg;
    logic [1:0]                    pp_pos_reg;
    logic [pcorr_pkg::MSTEP_W-1:0] step_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [HW-1:0]                 a_half;
    logic [HW-1:0]                 b_half;
    logic [pcorr_pkg::DWORD_W-1:0] pp_shifted;

    assign a_half = step_reg[0] ? a_reg[2*HW-1:HW] : a_reg[HW-1:0];
    assign b_half = step_reg[1] ? b_reg[2*HW-1:HW] : b_reg[HW-1:0];

    always_comb
    begin
        unique case (pp_pos_reg) inside
            2'd0:       pp_shifted = {{(2*HW){1'b0}}, pp_reg};
            2'd1, 2'd2: pp_shifted = {{HW{1'b0}}, pp_reg, {HW{1'b0}}};
            default:    pp_shifted = {pp_reg, {(2*HW){1'b0}}};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == pcorr_pkg::MUL_LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg != pcorr_pkg::MUL_LAST_STEP)
            begin
                pp_reg     <= a_half * b_half;
                pp_pos_reg <= step_reg[1:0];
            end
            if (step_reg != '0)
            begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ----- rtl/pcorr_dp.sv -----
// ----------------------------------------------------------------------------
// pcorr_dp
// Accumulators, final moment products, root search and result register.
// ----------------------------------------------------------------------------
module pcorr_dp
#(
    parameter int MAX_SAMPLES = pcorr_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = pcorr_pkg::DEF_SAMPLE_BITS
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pcorr_pkg::pcorr_cmd_t                 cmd,
    output pcorr_pkg::pcorr_sts_t                 sts,
    input  logic signed [SAMPLE_BITS-1:0]         x_sample,
    input  logic signed [SAMPLE_BITS-1:0]         y_sample,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic signed [pcorr_pkg::R_W-1:0]      r_value,
    output logic [pcorr_pkg::STATUS_W-1:0]        status
);

    localparam int WW     = pcorr_pkg::WORD_W;
    localparam int DW     = pcorr_pkg::DWORD_W;
    localparam int SW     = pcorr_pkg::SRCH_W;
    localparam int QB     = pcorr_pkg::Q_BITS;
    localparam int RW     = pcorr_pkg::R_W;
    localparam int SH     = 2 * pcorr_pkg::FRAC_BITS;
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = (SAMPLE_BITS + CNT_W > WW) ? WW : SAMPLE_BITS + CNT_W;
    localparam int PROD_W = (2 * SAMPLE_BITS + CNT_W - 1 > WW) ? WW
                          : 2 * SAMPLE_BITS + CNT_W - 1;

    logic [CNT_W-1:0]         count_reg;
    logic signed [SUM_W-1:0]  sum_x_reg;
    logic signed [SUM_W-1:0]  sum_y_reg;
    logic signed [PROD_W-1:0] sum_xy_reg;
    logic signed [PROD_W-1:0] sum_xx_reg;
    logic signed [PROD_W-1:0] sum_yy_reg;
    logic                     ovf_reg;

    logic signed [2*SAMPLE_BITS-1:0] xy_prod;
    logic signed [2*SAMPLE_BITS-1:0] xx_prod;
    logic signed [2*SAMPLE_BITS-1:0] yy_prod;

    logic [WW-1:0]  sxy_reg;
    logic [WW-1:0]  sxx_reg;
    logic [WW-1:0]  syy_reg;
    logic [DW-1:0]  pvar_reg;
    pcorr_pkg::mul_op_t op_reg;

    logic [SW-1:0]  rem_reg;
    logic [SW-1:0]  trial_reg;
    logic [SW-1:0]  d1_reg;
    logic [SW-1:0]  d2_reg;
    logic [QB-1:0]  q_reg;
    logic           sat_reg;

    logic                           res_valid_reg;
    logic signed [pcorr_pkg::R_W-1:0] r_reg;
    pcorr_pkg::status_t             status_reg;

    logic [WW-1:0]  mul_a;
    logic [WW-1:0]  mul_b;
    logic           mul_done;
    logic [DW-1:0]  mul_prod;
    logic [WW-1:0]  lo;
    logic           neg;
    logic [WW-1:0]  mag;
    logic           var_zero;
    logic [SW:0]    diff;
    logic           take;
    logic [SW-1:0]  d1_sum;
    logic [SW-1:0]  d1_new;
    logic [pcorr_pkg::R_W-1:0] q_ext;
    pcorr_pkg::status_t        status_next;
    logic [pcorr_pkg::R_W-1:0] r_next;
    logic           out_free;

    assign xy_prod = x_sample * y_sample;
    assign xx_prod = x_sample * x_sample;
    assign yy_prod = y_sample * y_sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xy_reg <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (cmd.clear)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xy_reg <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (cmd.accum)
        begin
            if (count_reg >= CNT_W'(MAX_SAMPLES))
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                count_reg  <= count_reg + 1'b1;
                sum_x_reg  <= sum_x_reg + SUM_W'(x_sample);
                sum_y_reg  <= sum_y_reg + SUM_W'(y_sample);
                sum_xy_reg <= sum_xy_reg + PROD_W'(xy_prod);
                sum_xx_reg <= sum_xx_reg + PROD_W'(xx_prod);
                sum_yy_reg <= sum_yy_reg + PROD_W'(yy_prod);
            end
        end
    end

    // two's complement: the low word of an unsigned product wraps like the signed one
    assign neg = sxy_reg[WW-1];
    assign mag = neg ? (WW'(0) - sxy_reg) : sxy_reg;

    always_comb
    begin
        unique case (cmd.mul_op)
            pcorr_pkg::OP_N_XY:
            begin
                mul_a = WW'(count_reg);
                mul_b = WW'(sum_xy_reg);
            end
            pcorr_pkg::OP_X_Y:
            begin
                mul_a = WW'(sum_x_reg);
                mul_b = WW'(sum_y_reg);
            end
            pcorr_pkg::OP_N_XX:
            begin
                mul_a = WW'(count_reg);
                mul_b = WW'(sum_xx_reg);
            end
            pcorr_pkg::OP_X_X:
            begin
                mul_a = WW'(sum_x_reg);
                mul_b = WW'(sum_x_reg);
            end
            pcorr_pkg::OP_N_YY:
            begin
                mul_a = WW'(count_reg);
                mul_b = WW'(sum_yy_reg);
            end
            pcorr_pkg::OP_Y_Y:
            begin
                mul_a = WW'(sum_y_reg);
                mul_b = WW'(sum_y_reg);
            end
            pcorr_pkg::OP_SXX_SYY:
            begin
                mul_a = sxx_reg;
                mul_b = syy_reg;
            end
            default:
            begin
                mul_a = mag;
                mul_b = mag;
            end
        endcase
    end

    pcorr_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign lo = mul_prod[WW-1:0];

    // root search: rem = B - q^2*P, d1 = q*P << (b+1), d2 = P << 2b
    assign diff   = {1'b0, rem_reg} - {1'b0, trial_reg};
    assign take   = !diff[SW] && !sat_reg;
    assign d1_sum = d1_reg + (d2_reg << 1);
    assign d1_new = take ? d1_sum : d1_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            op_reg <= cmd.mul_op;
        end
        if (mul_done)
        begin
            unique case (op_reg)
                pcorr_pkg::OP_N_XY:    sxy_reg  <= lo;
                pcorr_pkg::OP_X_Y:     sxy_reg  <= sxy_reg - lo;
                pcorr_pkg::OP_N_XX:    sxx_reg  <= lo;
                pcorr_pkg::OP_X_X:     sxx_reg  <= sxx_reg - lo;
                pcorr_pkg::OP_N_YY:    syy_reg  <= lo;
                pcorr_pkg::OP_Y_Y:     syy_reg  <= syy_reg - lo;
                pcorr_pkg::OP_SXX_SYY: pvar_reg <= mul_prod;
                default:
                begin
                    rem_reg <= SW'({mul_prod, {SH{1'b0}}});
                    d2_reg  <= SW'({pvar_reg, {SH{1'b0}}});
                    d1_reg  <= '0;
                    q_reg   <= '0;
                    sat_reg <= 1'b0;
                end
            endcase
        end
        if (cmd.srch_trial)
        begin
            trial_reg <= d1_reg + d2_reg;
        end
        if (cmd.srch_decide)
        begin
            if (take)
            begin
                rem_reg <= diff[SW-1:0];
            end
            if (take && cmd.srch_first)
            begin
                sat_reg <= 1'b1;
            end
            d1_reg <= d1_new >> 1;
            d2_reg <= d2_reg >> 2;
            q_reg  <= {q_reg[QB-2:0], take};
        end
    end

    assign var_zero = (sxx_reg == '0) || (syy_reg == '0);

    always_comb
    begin
        q_ext = RW'(q_reg);
        if (ovf_reg)
        begin
            status_next = pcorr_pkg::ST_OVF;
            r_next      = '0;
        end
        else if (var_zero)
        begin
            status_next = pcorr_pkg::ST_DEGEN;
            r_next      = '0;
        end
        else
        begin
            status_next = pcorr_pkg::ST_OK;
            r_next      = neg ? (RW'(0) - q_ext) : q_ext;
        end
    end

    assign out_free = !res_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            r_reg      <= r_next;
            status_reg <= status_next;
        end
    end

    assign sts.mul_done   = mul_done;
    assign sts.degenerate = var_zero;
    assign sts.overflow   = ovf_reg;
    assign sts.out_free   = out_free;

    assign result_valid = res_valid_reg;
    assign r_value      = r_reg;
    assign status       = status_reg;

endmodule

// ----- rtl/pcorr_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcorr_ctrl
// Sequencer: pair intake, moment products, root search and result hand-off.
// ----------------------------------------------------------------------------
module pcorr_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pair_valid,
    input  logic                  is_last,
    output logic                  pair_stall,
    output pcorr_pkg::pcorr_cmd_t cmd,
    input  pcorr_pkg::pcorr_sts_t sts
);

    localparam logic [2:0] S_ACC    = 3'd0;
    localparam logic [2:0] S_MUL_GO = 3'd1;
    localparam logic [2:0] S_MUL_WT = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_TRIAL  = 3'd4;
    localparam logic [2:0] S_DECIDE = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]                   state_reg;
    logic [2:0]                   state_next;
    pcorr_pkg::mul_op_t           op_reg;
    pcorr_pkg::mul_op_t           op_next;
    logic [pcorr_pkg::BIT_W-1:0]  bit_reg;
    logic [pcorr_pkg::BIT_W-1:0]  bit_next;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        bit_next        = bit_reg;
        pair_stall      = 1'b1;
        cmd             = '0;
        cmd.mul_op      = op_reg;
        cmd.srch_first  = (bit_reg == pcorr_pkg::SRCH_TOP);
        unique case (state_reg)
            S_ACC:
            begin
                pair_stall = 1'b0;
                cmd.accum  = pair_valid;
                if (pair_valid && is_last)
                begin
                    op_next    = pcorr_pkg::OP_N_XY;
                    state_next = S_MUL_GO;
                end
            end
            S_MUL_GO:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_MUL_WT;
            end
            S_MUL_WT:
            begin
                if (sts.mul_done)
                begin
                    if (op_reg == pcorr_pkg::OP_Y_Y)
                    begin
                        state_next = S_CHECK;
                    end
                    else if (op_reg == pcorr_pkg::OP_MAG_MAG)
                    begin
                        bit_next   = pcorr_pkg::SRCH_TOP;
                        state_next = S_TRIAL;
                    end
                    else
                    begin
                        op_next    = op_reg + 1'b1;
                        state_next = S_MUL_GO;
                    end
                end
            end
            S_CHECK:
            begin
                if (sts.overflow || sts.degenerate)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    op_next    = pcorr_pkg::OP_SXX_SYY;
                    state_next = S_MUL_GO;
                end
            end
            S_TRIAL:
            begin
                cmd.srch_trial = 1'b1;
                state_next     = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.srch_decide = 1'b1;
                if (bit_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = S_TRIAL;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACC;
            op_reg    <= pcorr_pkg::OP_N_XY;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            bit_reg   <= bit_next;
        end
    end

endmodule

// ----- rtl/pearson_correlation.sv -----
// ----------------------------------------------------------------------------
// pearson_correlation
// Streaming Pearson correlation coefficient of paired samples, signed Q1.14.
// ----------------------------------------------------------------------------
// Input channel (pair_valid / pair_stall): one (x, y) pair per beat; is_last
// closes the set. Pairs are taken one per cycle while accumulating.
// Output channel (result_valid / result_stall): one beat per set carrying
// r_value (r * 16384, truncated toward zero) and status (0 ok, 1 zero
// variance or fewer than two pairs, 2 too many pairs; r_value 0 if nonzero).
// After the last pair, eight 64x64 products run on one shared 32x32
// multiplier, then a 15-bit root search; when status is nonzero the last
// two products and the search are skipped.
// pair_stall is high during that time. Once the result sits in the output
// register the block takes the next set's pairs, even while the receiver
// stalls; a second result waits internally until the first beat is taken.
// Pairs beyond MAX_SAMPLES are dropped and flag status 2.
// Reset clears all sums, the pair count and the output valid.
// ----------------------------------------------------------------------------
module pearson_correlation
#(
    parameter int MAX_SAMPLES = pcorr_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = pcorr_pkg::DEF_SAMPLE_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pair_valid,
    output logic                                pair_stall,
    input  logic signed [SAMPLE_BITS-1:0]       x_sample,
    input  logic signed [SAMPLE_BITS-1:0]       y_sample,
    input  logic                                is_last,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [pcorr_pkg::R_W-1:0]    r_value,
    output logic [pcorr_pkg::STATUS_W-1:0]      status
);

    pcorr_pkg::pcorr_cmd_t cmd;
    pcorr_pkg::pcorr_sts_t sts;

    pcorr_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .is_last    (is_last),
        .pair_stall (pair_stall),
        .cmd        (cmd),
        .sts        (sts)
    );

    pcorr_dp
    #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .x_sample     (x_sample),
        .y_sample     (y_sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .r_value      (r_value),
        .status       (status)
    );

endmodule
